### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; depends on nothing else.
package spq_pkg;

	// Field widths of the request and result items.
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 3;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;

	// Default number of cells in the queue.
	localparam int QUEUE_DEPTH_DEF = 64;

	// Request kinds.
	typedef enum logic [0:0] {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_type_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Command broadcast to every cell in the row.
	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} spq_cmd_t;

endpackage

### sv/spq_cell.sv
// One slot of the sorted queue: holds an id and a priority and trades them
// with its neighbors on insert and removal. Depends on spq_pkg.
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                      clk,
	input  spq_pkg::spq_cmd_t         cmd,
	input  logic [CNT_W-1:0]          count,
	input  logic                      left_ge,
	input  logic [spq_pkg::ID_W-1:0]  left_id,
	input  logic [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic [spq_pkg::ID_W-1:0]  right_id,
	input  logic [spq_pkg::PRIO_W-1:0] right_prio,
	output logic [spq_pkg::ID_W-1:0]  id,
	output logic [spq_pkg::PRIO_W-1:0] prio,
	output logic                      ge
);

	logic [spq_pkg::ID_W-1:0]   id_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic                       occupied;

	// The slot is live when it lies below the entry count.
	assign occupied = (count > CNT_W'(INDEX));

	// This entry stays ahead of the new one when its priority is not lower.
	assign ge = occupied && (prio_q >= cmd.prio);

	// Keep, take the new entry, or shift in from a neighbor.
	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!ge) begin
				if (left_ge) begin
					id_q   <= cmd.id;
					prio_q <= cmd.prio;
				end else begin
					id_q   <= left_id;
					prio_q <= left_prio;
				end
			end
		end else if (cmd.deq) begin
			id_q   <= right_id;
			prio_q <= right_prio;
		end
	end

	assign id   = id_q;
	assign prio = prio_q;

endmodule

### sv/sorted_priority_queue_top.sv
// Sorted priority queue built as a row of shifting cells.
// A result item is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are drained; every cell compares and shifts at once.
// Reset: arst_n empties the queue and drops any pending result; the slot
// contents are left as they are and are never read before being written.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // entry_id [15:0], entry_priority [18:16]
	input  logic [0:0]  s_tuser,   // req_type [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // head_id [15:0], occupancy [22:16]
	output logic [1:0]  m_tuser    // status [1:0]
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                         accept;
	logic                         is_deq;
	logic                         is_full;
	logic                         is_empty;
	spq_pkg::spq_cmd_t            cmd;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_next;
	logic [CNT_W+spq_pkg::OCC_W-1:0] count_ext;

	logic [spq_pkg::ID_W-1:0]     cell_id   [QUEUE_DEPTH];
	logic [spq_pkg::PRIO_W-1:0]   cell_prio [QUEUE_DEPTH];
	logic                         cell_ge   [QUEUE_DEPTH];

	logic                         m_valid_q;
	spq_pkg::status_t             status_q;
	spq_pkg::status_t             status_next;
	logic [spq_pkg::ID_W-1:0]     head_q;
	logic [spq_pkg::ID_W-1:0]     head_next;
	logic [spq_pkg::OCC_W-1:0]    occ_q;

	// A new item is taken whenever the result register is free or draining.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign is_deq   = (spq_pkg::req_type_t'(s_tuser[0]) == spq_pkg::REQ_DEQ);
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	// Command to the cell row.
	always_comb begin
		cmd.enq  = accept && !is_deq && !is_full;
		cmd.deq  = accept && is_deq && !is_empty;
		cmd.id   = s_tdata[15:0];
		cmd.prio = s_tdata[18:16];
	end

	// Next entry count and result fields.
	always_comb begin
		count_next  = count_q;
		status_next = spq_pkg::ST_DONE;
		head_next   = '0;
		if (is_deq) begin
			if (is_empty) begin
				status_next = spq_pkg::ST_EMPTY;
			end else begin
				count_next = count_q - CNT_W'(1);
				head_next  = cell_id[0];
			end
		end else begin
			if (is_full) begin
				status_next = spq_pkg::ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end
	end

	assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

	// Row of cells, each wired to its left and right neighbor.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                       l_ge;
		logic [spq_pkg::ID_W-1:0]   l_id;
		logic [spq_pkg::PRIO_W-1:0] l_prio;
		logic [spq_pkg::ID_W-1:0]   r_id;
		logic [spq_pkg::PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_ge   = 1'b1;
			assign l_id   = cmd.id;
			assign l_prio = cmd.prio;
		end else begin : g_mid
			assign l_ge   = cell_ge[i-1];
			assign l_id   = cell_id[i-1];
			assign l_prio = cell_prio[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_id   = cell_id[i];
			assign r_prio = cell_prio[i];
		end else begin : g_body
			assign r_id   = cell_id[i+1];
			assign r_prio = cell_prio[i+1];
		end

		spq_cell #(
			.INDEX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_ge   (l_ge),
			.left_id   (l_id),
			.left_prio (l_prio),
			.right_id  (r_id),
			.right_prio(r_prio),
			.id        (cell_id[i]),
			.prio      (cell_prio[i]),
			.ge        (cell_ge[i])
		);
	end

	// Entry count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			head_q   <= head_next;
			occ_q    <= count_ext[spq_pkg::OCC_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, occ_q, head_q};
	assign m_tuser  = status_q;

endmodule
